FILE: rtl/core/ircfd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ircfd_pkg
// Shared types and constants for the IR climate frame decoder.
// ----------------------------------------------------------------------------
package ircfd_pkg;

	localparam int unsigned FRAME_BYTES_DEF = 13;

	localparam logic [15:0] HDR_MARK_RST   = 16'd9000;
	localparam logic [15:0] HDR_SPACE_RST  = 16'd4500;
	localparam logic [15:0] BIT_MARK_RST   = 16'd575;
	localparam logic [15:0] ONE_SPACE_RST  = 16'd1675;
	localparam logic [15:0] ZERO_SPACE_RST = 16'd550;
	localparam logic [6:0]  TOL_PCT_RST    = 7'd25;
	localparam logic [7:0]  SIGNATURE_RST  = 8'hc3;

	localparam int unsigned BOUND_W = 24;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_HEADER    = 3'd1,
		ST_BIT       = 3'd2,
		ST_FOOTER    = 3'd3,
		ST_CHECKSUM  = 3'd4,
		ST_SIGNATURE = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		MODE_OFF     = 3'd0,
		MODE_AUTO    = 3'd1,
		MODE_COOL    = 3'd2,
		MODE_DRY     = 3'd3,
		MODE_HEAT    = 3'd4,
		MODE_FAN     = 3'd5,
		MODE_UNKNOWN = 3'd6
	} ac_mode_t;

	typedef enum logic [1:0] {
		FAN_AUTO   = 2'd0,
		FAN_LOW    = 2'd1,
		FAN_MEDIUM = 2'd2,
		FAN_HIGH   = 2'd3
	} fan_t;

	typedef struct packed {
		logic        pulse_level;
		logic [15:0] pulse_us;
	} pulse_t;

	typedef struct packed {
		status_t    frame_status;
		logic       power_on;
		ac_mode_t   ac_mode;
		logic [5:0] set_temp_c;
		fan_t       fan_speed;
		logic [1:0] swing_state;
	} frame_t;

	// Scaled window bounds: a duration m fits when 100*m+99 >= lo and 100*m <= hi.
	typedef struct packed {
		logic [BOUND_W-1:0] lo;
		logic [BOUND_W-1:0] hi;
	} win_t;

	typedef struct packed {
		win_t       hdr_mark;
		win_t       hdr_space;
		win_t       bit_mark;
		win_t       one_space;
		win_t       zero_space;
		logic [7:0] signature;
	} win_set_t;

endpackage
`default_nettype wire

FILE: rtl/core/ir_climate_frame_decoder_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ir_climate_frame_decoder_top
// Pulse-distance IR frame decoder: header, LSB-first data bytes with running
// checksum, footer; emits one status/settings transaction per frame.
// ----------------------------------------------------------------------------
//  channel   | valid        | stall        | payload
//  ----------+--------------+--------------+---------------------
//  pulse     | pulse_valid  | pulse_stall  | pulse (pulse_t)
//  frame     | frame_valid  | frame_stall  | frame (frame_t)
//  config    | APB write: psel & penable & pwrite, pready tied high
//
// One pulse per cycle while pulse_stall is low. A pulse is held in the input
// register, decoded by the phase logic; a result lands in the result register.
// pulse_stall rises only when a pulse that gives a result (a frame or an error
// status) meets a stalled, full result register; other pulses keep flowing.
// Reset returns the receiver to idle, clears bit count and checksum, and loads
// the default timing registers; bounds are registered from them.
// ----------------------------------------------------------------------------
module ir_climate_frame_decoder_top #(
	parameter int unsigned FRAME_BYTES = ircfd_pkg::FRAME_BYTES_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [4:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	input  wire logic                pulse_valid,
	output logic                     pulse_stall,
	input  wire ircfd_pkg::pulse_t   pulse,
	output logic                     frame_valid,
	input  wire logic                frame_stall,
	output ircfd_pkg::frame_t        frame
);

	localparam int unsigned BW       = ircfd_pkg::BOUND_W;
	localparam int unsigned TOTAL    = FRAME_BYTES * 8;
	localparam int unsigned BCW      = $clog2(TOTAL + 1);
	localparam int unsigned STORE    = (FRAME_BYTES > 10) ? FRAME_BYTES : 10;
	localparam int unsigned IDXW     = $clog2(STORE);
	localparam int unsigned LAST_IDX = FRAME_BYTES - 1;

	localparam logic [2:0] MCODE_AUTO = 3'b000;
	localparam logic [2:0] MCODE_COOL = 3'b001;
	localparam logic [2:0] MCODE_DRY  = 3'b010;
	localparam logic [2:0] MCODE_HEAT = 3'b100;
	localparam logic [2:0] MCODE_FAN  = 3'b110;
	localparam logic [2:0] FCODE_HIGH = 3'b001;
	localparam logic [2:0] FCODE_MED  = 3'b010;
	localparam logic [2:0] FCODE_LOW  = 3'b011;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HDR_SPACE,
		PH_BIT_MARK,
		PH_BIT_SPACE,
		PH_FOOTER
	} phase_t;

	ircfd_pkg::win_set_t win;

	logic              pulse_vld_s1;
	ircfd_pkg::pulse_t pulse_s1;

	phase_t            phase_q, phase_nxt;
	logic [BCW-1:0]    bit_count_q;
	logic [7:0]        sum_q;
	logic [7:0]        shift_q;
	logic [7:0]        frame_mem_q [STORE];
	logic              frame_valid_q;
	ircfd_pkg::frame_t frame_q;

	logic [BW-1:0]     m100, m100_top;
	logic              in_hdr_mark, in_hdr_space, in_bit_mark, in_one, in_zero;
	logic              emit, start, bit_take, bit_val, fire, out_free;
	logic              last_bit, byte_done, pulse_take;
	logic [IDXW-1:0]   idx;
	logic [7:0]        new_byte;
	ircfd_pkg::frame_t res, done_res;
	logic [7:0]        b0, b1, b2, b4, b6, b9, b_last;

	ircfd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.win     (win)
	);

	function automatic logic fits(input logic [BW-1:0] lo_b, input logic [BW-1:0] hi_b,
			input logic [BW-1:0] v, input logic [BW-1:0] v_top);
		fits = (v_top >= lo_b) && (v <= hi_b);
	endfunction

	assign m100     = BW'(pulse_s1.pulse_us) * BW'(7'd100);
	assign m100_top = m100 + BW'(7'd99);

	assign in_hdr_mark  = fits(win.hdr_mark.lo, win.hdr_mark.hi, m100, m100_top);
	assign in_hdr_space = fits(win.hdr_space.lo, win.hdr_space.hi, m100, m100_top);
	assign in_bit_mark  = fits(win.bit_mark.lo, win.bit_mark.hi, m100, m100_top);
	assign in_one       = fits(win.one_space.lo, win.one_space.hi, m100, m100_top);
	assign in_zero      = fits(win.zero_space.lo, win.zero_space.hi, m100, m100_top);

	assign last_bit  = (bit_count_q == BCW'(TOTAL - 1));
	assign byte_done = (bit_count_q[2:0] == 3'b111);
	assign idx       = IDXW'(bit_count_q >> 3);
	assign new_byte  = {bit_val, shift_q[7:1]};

	// bytes past the frame length read as zero
	assign b0     = frame_mem_q[0];
	assign b1     = frame_mem_q[1];
	assign b2     = (FRAME_BYTES > 2) ? frame_mem_q[2] : 8'd0;
	assign b4     = (FRAME_BYTES > 4) ? frame_mem_q[4] : 8'd0;
	assign b6     = (FRAME_BYTES > 6) ? frame_mem_q[6] : 8'd0;
	assign b9     = (FRAME_BYTES > 9) ? frame_mem_q[9] : 8'd0;
	assign b_last = frame_mem_q[IDXW'(LAST_IDX)];

	always_comb begin
		done_res = '0;
		if (sum_q != b_last) begin
			done_res.frame_status = ircfd_pkg::ST_CHECKSUM;
		end else if (b0 != win.signature) begin
			done_res.frame_status = ircfd_pkg::ST_SIGNATURE;
		end else begin
			done_res.frame_status = ircfd_pkg::ST_OK;
			done_res.power_on     = b9[5];
			if (!b9[5]) begin
				done_res.ac_mode = ircfd_pkg::MODE_OFF;
			end else begin
				case (b6[7:5])
					MCODE_AUTO: done_res.ac_mode = ircfd_pkg::MODE_AUTO;
					MCODE_COOL: done_res.ac_mode = ircfd_pkg::MODE_COOL;
					MCODE_DRY:  done_res.ac_mode = ircfd_pkg::MODE_DRY;
					MCODE_HEAT: done_res.ac_mode = ircfd_pkg::MODE_HEAT;
					MCODE_FAN:  done_res.ac_mode = ircfd_pkg::MODE_FAN;
					default:    done_res.ac_mode = ircfd_pkg::MODE_UNKNOWN;
				endcase
			end
			done_res.set_temp_c = 6'(b1[7:3]) + 6'd8;
			case (b4[7:5])
				FCODE_HIGH: done_res.fan_speed = ircfd_pkg::FAN_HIGH;
				FCODE_MED:  done_res.fan_speed = ircfd_pkg::FAN_MEDIUM;
				FCODE_LOW:  done_res.fan_speed = ircfd_pkg::FAN_LOW;
				default:    done_res.fan_speed = ircfd_pkg::FAN_AUTO;
			endcase
			done_res.swing_state = {b2[7:5] != 3'b111, b1[2:0] != 3'b111};
		end
	end

	always_comb begin
		phase_nxt = phase_q;
		emit      = 1'b0;
		start     = 1'b0;
		bit_take  = 1'b0;
		bit_val   = 1'b0;
		res       = '0;
		case (phase_q)
			PH_IDLE: begin
				// spaces between frames are dropped
				if (pulse_s1.pulse_level) begin
					if (in_hdr_mark) begin
						phase_nxt = PH_HDR_SPACE;
					end else begin
						emit             = 1'b1;
						res.frame_status = ircfd_pkg::ST_HEADER;
					end
				end
			end
			PH_HDR_SPACE: begin
				if (!pulse_s1.pulse_level && in_hdr_space) begin
					phase_nxt = PH_BIT_MARK;
					start     = 1'b1;
				end else begin
					phase_nxt        = PH_IDLE;
					emit             = 1'b1;
					res.frame_status = ircfd_pkg::ST_HEADER;
				end
			end
			PH_BIT_MARK: begin
				if (pulse_s1.pulse_level && in_bit_mark) begin
					phase_nxt = PH_BIT_SPACE;
				end else begin
					phase_nxt        = PH_IDLE;
					emit             = 1'b1;
					res.frame_status = ircfd_pkg::ST_BIT;
				end
			end
			PH_BIT_SPACE: begin
				if (!pulse_s1.pulse_level && (in_one || in_zero)) begin
					bit_take  = 1'b1;
					bit_val   = in_one;
					phase_nxt = last_bit ? PH_FOOTER : PH_BIT_MARK;
				end else begin
					phase_nxt        = PH_IDLE;
					emit             = 1'b1;
					res.frame_status = ircfd_pkg::ST_BIT;
				end
			end
			PH_FOOTER: begin
				phase_nxt = PH_IDLE;
				emit      = 1'b1;
				if (pulse_s1.pulse_level && in_bit_mark) begin
					res = done_res;
				end else begin
					res.frame_status = ircfd_pkg::ST_FOOTER;
				end
			end
			default: phase_nxt = PH_IDLE;
		endcase
	end

	assign out_free    = !frame_valid_q || !frame_stall;
	assign fire        = pulse_vld_s1 && (!emit || out_free);
	assign pulse_stall = pulse_vld_s1 && !fire;
	assign pulse_take  = pulse_valid && !pulse_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_vld_s1  <= 1'b0;
			phase_q       <= PH_IDLE;
			bit_count_q   <= '0;
			sum_q         <= 8'd0;
			frame_valid_q <= 1'b0;
		end else begin
			if (!pulse_vld_s1 || fire) begin
				pulse_vld_s1 <= pulse_valid;
			end
			if (fire) begin
				phase_q <= phase_nxt;
				if (start) begin
					bit_count_q <= '0;
					sum_q       <= 8'd0;
				end
				if (bit_take) begin
					bit_count_q <= bit_count_q + BCW'(1);
					if (byte_done && (idx != IDXW'(LAST_IDX))) begin
						sum_q <= sum_q + new_byte;
					end
				end
			end
			if (fire && emit) begin
				frame_valid_q <= 1'b1;
			end else if (frame_valid_q && !frame_stall) begin
				frame_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pulse_take) begin
			pulse_s1 <= pulse;
		end
		if (fire && bit_take) begin
			shift_q <= new_byte;
			if (byte_done) begin
				frame_mem_q[idx] <= new_byte;
			end
		end
		if (fire && emit) begin
			frame_q <= res;
		end
	end

	assign frame_valid = frame_valid_q;
	assign frame       = frame_q;

endmodule
`default_nettype wire

FILE: rtl/core/ircfd_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ircfd_cfg
// APB register file for the timing setup and signature; turns each expected
// duration and the tolerance into registered, scaled acceptance bounds.
// ----------------------------------------------------------------------------
module ircfd_cfg (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [4:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	output ircfd_pkg::win_set_t     win
);

	localparam logic [2:0] REG_HDR_MARK   = 3'd0;
	localparam logic [2:0] REG_HDR_SPACE  = 3'd1;
	localparam logic [2:0] REG_BIT_MARK   = 3'd2;
	localparam logic [2:0] REG_ONE_SPACE  = 3'd3;
	localparam logic [2:0] REG_ZERO_SPACE = 3'd4;
	localparam logic [2:0] REG_TOL_PCT    = 3'd5;
	localparam logic [2:0] REG_SIGNATURE  = 3'd6;

	localparam int unsigned BW = ircfd_pkg::BOUND_W;

	logic [15:0] hdr_mark_q, hdr_space_q, bit_mark_q, one_space_q, zero_space_q;
	logic [6:0]  tol_pct_q;
	logic [7:0]  signature_q;
	logic [2:0]  reg_idx;
	logic        wr_en;
	logic [6:0]  tol_lo;
	logic [BW-1:0] lo_f, hi_f;
	ircfd_pkg::win_set_t win_q;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_mark_q   <= ircfd_pkg::HDR_MARK_RST;
			hdr_space_q  <= ircfd_pkg::HDR_SPACE_RST;
			bit_mark_q   <= ircfd_pkg::BIT_MARK_RST;
			one_space_q  <= ircfd_pkg::ONE_SPACE_RST;
			zero_space_q <= ircfd_pkg::ZERO_SPACE_RST;
			tol_pct_q    <= ircfd_pkg::TOL_PCT_RST;
			signature_q  <= ircfd_pkg::SIGNATURE_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_HDR_MARK:   hdr_mark_q   <= pwdata[15:0];
				REG_HDR_SPACE:  hdr_space_q  <= pwdata[15:0];
				REG_BIT_MARK:   bit_mark_q   <= pwdata[15:0];
				REG_ONE_SPACE:  one_space_q  <= pwdata[15:0];
				REG_ZERO_SPACE: zero_space_q <= pwdata[15:0];
				REG_TOL_PCT:    tol_pct_q    <= pwdata[6:0];
				REG_SIGNATURE:  signature_q  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_HDR_MARK:   prdata = {16'd0, hdr_mark_q};
			REG_HDR_SPACE:  prdata = {16'd0, hdr_space_q};
			REG_BIT_MARK:   prdata = {16'd0, bit_mark_q};
			REG_ONE_SPACE:  prdata = {16'd0, one_space_q};
			REG_ZERO_SPACE: prdata = {16'd0, zero_space_q};
			REG_TOL_PCT:    prdata = {25'd0, tol_pct_q};
			REG_SIGNATURE:  prdata = {24'd0, signature_q};
			default:        prdata = 32'd0;
		endcase
	end

	// lower factor clamps at zero once tolerance passes 100 percent
	assign tol_lo = (tol_pct_q > 7'd100) ? 7'd100 : tol_pct_q;
	assign lo_f   = BW'(7'd100 - tol_lo);
	assign hi_f   = BW'(8'd100 + {1'b0, tol_pct_q});

	// bounds are data only; they are registered from the current register values
	always_ff @(posedge clk) begin
		win_q.hdr_mark.lo   <= BW'(hdr_mark_q)   * lo_f;
		win_q.hdr_mark.hi   <= BW'(hdr_mark_q)   * hi_f;
		win_q.hdr_space.lo  <= BW'(hdr_space_q)  * lo_f;
		win_q.hdr_space.hi  <= BW'(hdr_space_q)  * hi_f;
		win_q.bit_mark.lo   <= BW'(bit_mark_q)   * lo_f;
		win_q.bit_mark.hi   <= BW'(bit_mark_q)   * hi_f;
		win_q.one_space.lo  <= BW'(one_space_q)  * lo_f;
		win_q.one_space.hi  <= BW'(one_space_q)  * hi_f;
		win_q.zero_space.lo <= BW'(zero_space_q) * lo_f;
		win_q.zero_space.hi <= BW'(zero_space_q) * hi_f;
		win_q.signature     <= signature_q;
	end

	assign win = win_q;

endmodule
`default_nettype wire

FILE: rtl/core/ircfd_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ircfd_chk
// Port-level checks for the IR climate frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module ircfd_chk (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              pulse_stall,
	input wire logic              frame_valid,
	input wire logic              frame_stall,
	input wire ircfd_pkg::frame_t frame
);

	// a held result transaction keeps its contents
	a_frame_hold: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && frame_stall |=> frame_valid && $stable(frame))
		else $error("frame changed while stalled");

	// input backpressure only comes from a blocked result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pulse_stall |-> frame_valid && frame_stall)
		else $error("pulse stalled without a blocked frame");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && (frame.frame_status != ircfd_pkg::ST_OK) |->
		!frame.power_on && (frame.ac_mode == ircfd_pkg::MODE_OFF) &&
		(frame.set_temp_c == 6'd0) && (frame.fan_speed == ircfd_pkg::FAN_AUTO) &&
		(frame.swing_state == 2'd0))
		else $error("failed frame carries decoded fields");

	a_ok_temp: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && (frame.frame_status == ircfd_pkg::ST_OK) |->
		(frame.set_temp_c >= 6'd8) && (frame.set_temp_c <= 6'd39))
		else $error("decoded temperature out of range");

	a_ok_power: assert property (@(posedge clk) disable iff (!arst_n)
		frame_valid && (frame.frame_status == ircfd_pkg::ST_OK) |->
		(frame.power_on == (frame.ac_mode != ircfd_pkg::MODE_OFF)))
		else $error("mode and power bit disagree");

endmodule

bind ir_climate_frame_decoder_top ircfd_chk u_ircfd_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.pulse_stall (pulse_stall),
	.frame_valid (frame_valid),
	.frame_stall (frame_stall),
	.frame       (frame)
);
`default_nettype wire
